// File: hdl/keyed_length_prefixed_deframer_assert.svh
// Assertion macros for the keyed length-prefixed deframer.
`ifndef KEYED_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define KEYED_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, quiet in reset.
`define KLD_ASSERT_IMPLIES(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("deframer check failed: same-cycle implication");
// Next-cycle implication, sampled on clk, quiet in reset.
`define KLD_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("deframer check failed: next-cycle implication");
`else
`define KLD_ASSERT_IMPLIES(name, pre, post)
`define KLD_ASSERT_NEXT(name, pre, post)
`endif
`endif

// File: hdl/kld_pkg.sv
// Shared types and constants for the keyed length-prefixed deframer.
`timescale 1ns / 1ps
package kld_pkg;

    // Frame layout
    localparam int KEY_BYTES_DEF = 32;
    localparam int LENGTH_BYTES  = 4;

    // Reset value of the maximum payload length register
    localparam logic [31:0] MAX_PAYLOAD_LENGTH_RST = 32'd65535;

    // Part tags on the output
    localparam logic [1:0] PART_KEY = 2'd0;
    localparam logic [1:0] PART_LEN = 2'd1;
    localparam logic [1:0] PART_PAY = 2'd2;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_KEY = 3'b001,
        PH_LEN = 3'b010,
        PH_PAY = 3'b100
    } kld_phase_t;

    // One result beat
    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  part;
        logic [31:0] part_index;
        logic [31:0] frame_length;
        logic        length_valid;
        logic        frame_end;
        logic        length_error;
    } kld_result_t;

endpackage

// File: hdl/kld_parser.sv
// Frame parser: phase, position and length state plus per-byte tagging.
`timescale 1ns / 1ps
module kld_parser
    import kld_pkg::*;
#(
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    input  logic [31:0] len_limit,
    output kld_result_t result
);

    kld_phase_t  phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;

    // Effective state after a restart
    kld_phase_t  ph_cur;
    logic [31:0] pos_cur;
    logic [31:0] acc_cur;
    logic [31:0] acc_shift;
    logic [32:0] pos_inc;

    always_comb
    begin
        if (restart)
        begin
            ph_cur  = PH_KEY;
            pos_cur = '0;
            acc_cur = '0;
        end
        else
        begin
            ph_cur  = phase_reg;
            pos_cur = pos_reg;
            acc_cur = acc_reg;
        end
    end

    assign acc_shift = {acc_cur[23:0], data_byte};
    assign pos_inc   = {1'b0, pos_cur} + 33'd1;

    // Per-byte step
    always_comb
    begin
        phase_next          = ph_cur;
        pos_next            = pos_cur;
        acc_next            = acc_cur;
        result.byte_out     = data_byte;
        result.part         = PART_KEY;
        result.part_index   = pos_cur;
        result.frame_length = '0;
        result.length_valid = 1'b0;
        result.frame_end    = 1'b0;
        result.length_error = 1'b0;
        unique case (ph_cur)
            PH_KEY:
            begin
                if (pos_cur == 32'(KEY_BYTES - 1))
                begin
                    phase_next = PH_LEN;
                    pos_next   = '0;
                    acc_next   = '0;
                end
                else
                begin
                    pos_next = pos_inc[31:0];
                end
            end
            PH_LEN:
            begin
                result.part = PART_LEN;
                acc_next    = acc_shift;
                if (pos_cur == 32'(LENGTH_BYTES - 1))
                begin
                    result.frame_length = acc_shift;
                    result.length_valid = 1'b1;
                    pos_next            = '0;
                    if (acc_shift > len_limit)
                    begin
                        result.length_error = 1'b1;
                        phase_next          = PH_KEY;
                        acc_next            = '0;
                    end
                    else if (acc_shift == 32'd0)
                    begin
                        result.frame_end = 1'b1;
                        phase_next       = PH_KEY;
                        acc_next         = '0;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                    end
                end
                else
                begin
                    pos_next = pos_inc[31:0];
                end
            end
            PH_PAY:
            begin
                result.part = PART_PAY;
                // 33-bit compare also closes a frame at the position limit
                if (pos_inc >= {1'b0, acc_cur})
                begin
                    result.frame_end = 1'b1;
                    phase_next       = PH_KEY;
                    pos_next         = '0;
                    acc_next         = '0;
                end
                else
                begin
                    pos_next = pos_inc[31:0];
                end
            end
            default:
            begin
                // Illegal phase code: restart as key byte 0
                result.part_index = '0;
                phase_next        = PH_KEY;
                pos_next          = (KEY_BYTES == 1) ? 32'd0 : 32'd1;
                acc_next          = '0;
                if (KEY_BYTES == 1)
                begin
                    phase_next = PH_LEN;
                end
            end
        endcase
    end

    // State registers, updated once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEY;
            pos_reg   <= '0;
            acc_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// File: hdl/kld_out_reg.sv
// Result register with pass-through ready for back-to-back beats.
`timescale 1ns / 1ps
module kld_out_reg
    import kld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  kld_result_t in_result,
    output logic        out_valid,
    input  logic        out_ready,
    output kld_result_t out_result
);

    logic        valid_reg;
    kld_result_t data_reg;
    logic        load;

    // Free slot, or the held beat leaves this cycle
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = data_reg;

endmodule

// File: hdl/keyed_length_prefixed_deframer.sv
// Keyed length-prefixed deframer, top level.
//
// Splits a byte stream into frames of KEY_BYTES key-id bytes, a 4-byte
// big-endian payload length and that many payload bytes, and tags every
// byte with its part and its index within the part. The decoded length
// comes out on the last length byte; a length above the configured maximum
// raises length_error and the next byte starts a new key id. frame_end
// marks the last payload byte, or the last length byte of a zero-length
// frame. restart makes the byte it arrives with key-id byte 0. One byte is
// accepted per clock while the single output register is empty or being read
// (in_ready high); on the accepting edge the parser updates its state and the
// result lands in that register. The user writes the maximum payload length
// through cfg_we / cfg_wdata only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "keyed_length_prefixed_deframer_assert.svh"
module keyed_length_prefixed_deframer
    import kld_pkg::*;
#(
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // Input beats
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    // Output beats
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_out,
    output logic [1:0]  part,
    output logic [31:0] part_index,
    output logic [31:0] frame_length,
    output logic        length_valid,
    output logic        frame_end,
    output logic        length_error
);

    logic [31:0] max_len_reg;
    logic        in_fire;
    kld_result_t step_result;
    kld_result_t held_result;

    // Maximum payload length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_PAYLOAD_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    assign in_fire = in_valid && in_ready;

    // Parser
    kld_parser #(
        .KEY_BYTES (KEY_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (in_fire),
        .data_byte (data_byte),
        .restart   (restart),
        .len_limit (max_len_reg),
        .result    (step_result)
    );

    // Output register
    kld_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_result  (step_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (held_result)
    );

    assign byte_out     = held_result.byte_out;
    assign part         = held_result.part;
    assign part_index   = held_result.part_index;
    assign frame_length = held_result.frame_length;
    assign length_valid = held_result.length_valid;
    assign frame_end    = held_result.frame_end;
    assign length_error = held_result.length_error;

    // Checks
    `KLD_ASSERT_IMPLIES(a_err_flags, out_valid && length_error, length_valid && !frame_end)
    `KLD_ASSERT_IMPLIES(a_len_only_on_len, out_valid && (part != PART_LEN), !length_valid && (frame_length == 32'd0))
    `KLD_ASSERT_IMPLIES(a_end_part, out_valid && frame_end, (part == PART_PAY) || ((part == PART_LEN) && (frame_length == 32'd0)))
    `KLD_ASSERT_NEXT(a_restart_key0, in_fire && restart, out_valid && (part == PART_KEY) && (part_index == 32'd0))

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the keyed length-prefixed deframer.
`timescale 1ns / 1ps
module testbench;
    import kld_pkg::*;

    localparam int KEY_LEN      = KEY_BYTES_DEF;
    localparam int HEADER_LEN   = KEY_LEN + LENGTH_BYTES;
    localparam int WHOLE_FRAME  = 1 << 30;
    localparam int IDLE_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_BYTES  = 270;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        restart;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  byte_out;
    logic [1:0]  part;
    logic [31:0] part_index;
    logic [31:0] frame_length;
    logic        length_valid;
    logic        frame_end;
    logic        length_error;

    // Parser copy used for prediction
    kld_phase_t  model_phase;
    logic [31:0] model_pos;
    logic [31:0] model_len_acc;
    logic [31:0] model_max_len;

    kld_result_t expected_beats[$];

    int error_count;
    int report_count;
    int idle_cycles;
    int sent_count;
    int frames_done;
    int length_errors;
    int restarts_seen;
    int limits_used;
    bit no_idle;
    bit resync_next;

    keyed_length_prefixed_deframer #(
        .KEY_BYTES(KEY_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .restart(restart),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .byte_out(byte_out),
        .part(part),
        .part_index(part_index),
        .frame_length(frame_length),
        .length_valid(length_valid),
        .frame_end(frame_end),
        .length_error(length_error)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Drop back to the key-id phase
    function automatic void clear_frame_state();
        model_phase   = PH_KEY;
        model_pos     = 32'd0;
        model_len_acc = 32'd0;
    endfunction

    // Predict the beat produced by one stream byte and advance the parser copy
    function automatic kld_result_t deframe_byte(input logic [7:0] b, input logic rs);
        kld_result_t r;
        r = '0;
        r.byte_out = b;
        if (rs || (model_phase != PH_KEY && model_phase != PH_LEN && model_phase != PH_PAY))
            clear_frame_state();
        r.part_index = model_pos;
        case (model_phase)
            PH_LEN:
            begin
                r.part = PART_LEN;
                model_len_acc = {model_len_acc[23:0], b};
                if (model_pos + 32'd1 >= LENGTH_BYTES)
                begin
                    r.frame_length = model_len_acc;
                    r.length_valid = 1'b1;
                    model_pos = 32'd0;
                    if (model_len_acc > model_max_len)
                    begin
                        r.length_error = 1'b1;
                        clear_frame_state();
                    end
                    else if (model_len_acc == 32'd0)
                    begin
                        r.frame_end = 1'b1;
                        clear_frame_state();
                    end
                    else
                        model_phase = PH_PAY;
                end
                else
                    model_pos = model_pos + 32'd1;
            end
            PH_PAY:
            begin
                r.part = PART_PAY;
                if (model_pos + 32'd1 >= model_len_acc || model_pos == 32'hFFFF_FFFF)
                begin
                    r.frame_end = 1'b1;
                    clear_frame_state();
                end
                else
                    model_pos = model_pos + 32'd1;
            end
            default:
            begin
                r.part = PART_KEY;
                if (model_pos + 32'd1 >= KEY_LEN)
                begin
                    model_phase   = PH_LEN;
                    model_pos     = 32'd0;
                    model_len_acc = 32'd0;
                end
                else
                    model_pos = model_pos + 32'd1;
            end
        endcase
        return r;
    endfunction

    function automatic string beat_text(input kld_result_t r);
        return $sformatf("byte=%h part=%0d idx=%0d len=%h lv=%b fe=%b le=%b",
                         r.byte_out, r.part, r.part_index, r.frame_length,
                         r.length_valid, r.frame_end, r.length_error);
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    // Score output beats against predictions, predict accepted input beats
    always @(posedge clk)
    begin : beat_monitor
        kld_result_t got;
        kld_result_t want;
        kld_result_t pred;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.byte_out     = byte_out;
                got.part         = part;
                got.part_index   = part_index;
                got.frame_length = frame_length;
                got.length_valid = length_valid;
                got.frame_end    = frame_end;
                got.length_error = length_error;
                if (expected_beats.size() == 0)
                begin
                    error_count++;
                    if (report_count < MAX_REPORTS)
                        $display("%0t: output beat with nothing expected: %s",
                                 $realtime, beat_text(got));
                    report_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        if (report_count < MAX_REPORTS)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $realtime, beat_text(want), beat_text(got));
                        report_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pred = deframe_byte(data_byte, restart);
                expected_beats.push_back(pred);
                frames_done   += pred.frame_end;
                length_errors += pred.length_error;
                restarts_seen += restart;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on stalled handshakes
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stall before each beat
    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Send one stream byte; entered and left at a falling edge
    task automatic send_stream_byte(input logic [7:0] b, input logic rs);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        restart   <= rs;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
        @(negedge clk);
    endtask

    // Key bytes, big-endian length, payload; stops after cut bytes
    task automatic send_frame(input logic [31:0] len, input int pay_cnt, input int cut,
                              input bit rs_first, input bit noisy, input int fill);
        int total;
        logic [7:0] b;
        bit rs;
        total = HEADER_LEN + pay_cnt;
        for (int i = 0; i < total && i < cut; i++)
        begin
            if (i >= KEY_LEN && i < HEADER_LEN)
                b = 8'(len >> (8 * (HEADER_LEN - 1 - i)));
            else
                b = (fill < 0) ? 8'($urandom) : 8'(fill);
            rs = (i == 0 && rs_first) || (noisy && $urandom_range(0, 15) == 0);
            send_stream_byte(b, rs);
        end
    endtask

    // Wait until every predicted beat has come out, then let the bench settle
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_max_length(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        model_max_len = value;
        limits_used++;
    endtask

    // Reset limit: short frame, zero length, one above the limit, one-byte frame
    task automatic test_reset_limit();
        no_idle = 1'b0;
        send_frame(32'd2, 2, WHOLE_FRAME, 1'b1, 1'b0, 8'h00);
        send_frame(32'd0, 0, WHOLE_FRAME, 1'b0, 1'b0, 8'hFF);
        send_frame(32'h0001_0000, 0, WHOLE_FRAME, 1'b0, 1'b0, -1);
        send_frame(32'd1, 1, WHOLE_FRAME, 1'b0, 1'b0, -1);
    endtask

    // Limit at both ends of its range
    task automatic test_limit_extremes();
        settle_idle();
        write_max_length(32'd0);
        send_frame(32'd0, 0, WHOLE_FRAME, 1'b0, 1'b0, -1);
        send_frame(32'd1, 0, WHOLE_FRAME, 1'b0, 1'b0, -1);
        settle_idle();
        write_max_length(32'hFFFF_FFFF);
        // huge accepted length, cut short by a restart in the payload
        send_frame(32'hFFFF_FFFF, 3, WHOLE_FRAME, 1'b0, 1'b0, -1);
        send_frame(32'd1, 1, WHOLE_FRAME, 1'b1, 1'b0, -1);
    endtask

    // Restart landing in the key id and in the length field
    task automatic test_restart_mid_part();
        no_idle = 1'b1;
        send_frame(32'd5, 5, 10, 1'b0, 1'b0, -1);
        send_frame(32'd5, 5, KEY_LEN + 2, 1'b1, 1'b0, -1);
        no_idle = 1'b0;
        send_frame(32'd3, 3, WHOLE_FRAME, 1'b1, 1'b0, -1);
    endtask

    // One random frame: mostly well formed, some oversize, cut short or noisy
    task automatic random_frame(input logic [31:0] limit);
        int kind;
        int cap;
        int len;
        bit rs_first;
        longint unsigned span;
        longint unsigned pick;
        logic [31:0] big_len;
        kind     = $urandom_range(0, 99);
        no_idle  = ($urandom_range(0, 3) == 0);
        rs_first = ($urandom_range(0, 3) == 0) || resync_next;
        resync_next = 1'b0;
        cap = (limit < 32'd40) ? int'(limit) : 40;
        if (kind < 12 && limit != 32'hFFFF_FFFF)
        begin
            span = 64'hFFFF_FFFF - limit;
            pick = {$urandom, $urandom};
            if ($urandom_range(0, 1))
                big_len = limit + 32'd1;
            else
                big_len = 32'(longint'(limit) + 1 + (pick % span));
            send_frame(big_len, 0, WHOLE_FRAME, rs_first, 1'b0, -1);
        end
        else
        begin
            len = $urandom_range(0, cap);
            if (kind < 22)
            begin
                send_frame(len, len, $urandom_range(1, HEADER_LEN + len), rs_first, 1'b0, -1);
                resync_next = 1'b1;
            end
            else if (kind < 30)
            begin
                send_frame(len, len, WHOLE_FRAME, rs_first, 1'b1, -1);
                resync_next = 1'b1;
            end
            else
                send_frame(len, len, WHOLE_FRAME, rs_first, 1'b0, -1);
        end
    endtask

    // Random streams over several limit settings
    task automatic test_random_stream();
        logic [31:0] limit_set [5];
        int start;
        limit_set = '{MAX_PAYLOAD_LENGTH_RST, 32'd0, 32'($urandom_range(1, 50)),
                      32'hFFFF_FFFF, 32'($urandom)};
        foreach (limit_set[k])
        begin
            settle_idle();
            write_max_length(limit_set[k]);
            resync_next = 1'b1;
            start = sent_count;
            while (sent_count - start < PHASE_BYTES)
                random_frame(limit_set[k]);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 32'd0;
        in_valid    = 1'b0;
        data_byte   = 8'd0;
        restart     = 1'b0;
        error_count = 0;
        report_count = 0;
        idle_cycles = 0;
        sent_count  = 0;
        frames_done = 0;
        length_errors = 0;
        restarts_seen = 0;
        limits_used = 0;
        no_idle     = 1'b0;
        resync_next = 1'b0;
        model_max_len = MAX_PAYLOAD_LENGTH_RST;
        clear_frame_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_limit();
        test_limit_extremes();
        test_restart_mid_part();
        test_random_stream();

        settle_idle();
        if (expected_beats.size() != 0)
            error_count++;
        $display("Run covered %0d stream bytes under %0d written limits plus the reset one:",
                 sent_count, limits_used);
        $display("  %0d frames closed, %0d oversize lengths, %0d restarts; %0d errors",
                 frames_done, length_errors, restarts_seen, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
